// File: hdl/ffa_pkg.sv
package ffa_pkg;

  localparam int unsigned TableEntries = 4096;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam int unsigned DataW = 32;

  typedef enum logic {
    FuncAlloc = 1'b0,
    FuncFree  = 1'b1
  } func_e;

  // one table entry
  typedef struct packed {
    logic [DataW-1:0] start;
    logic [DataW-1:0] length;
  } region_t;

endpackage

// File: hdl/first_fit_free_list_allocator.sv
// channel  | dir | tdata (low bit first)                                   | tuser
// s_axis   | in  | addr[31:0], size[63:32]                                 | func
// m_axis   | out | alloc_addr, free_total, entry_count, peak_entries,
//          |     | lost_count, lost_bytes (154 bits, padded to 160)        | status
// one request at a time; the table lives in one memory with one read and one write port
// each request scans the table and may then shift entries to open or close a gap;
// the scan stops where the shift starts
// reset clears the registers but not the table; entries at or above the count are never used
// a result held on the master side blocks the next request until it is taken
module first_fit_free_list_allocator
  import ffa_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // addr[31:0], size[63:32]
  input  logic         s_axis_tuser,   // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata,   // alloc_addr, free_total, entry_count,
                                       // peak_entries, lost_count, lost_bytes
  output logic         m_axis_tuser    // status
);

  typedef enum logic [3:0] {
    StIdle, StScanRd, StScanChk, StPrevRd, StPrevChk, StDecide,
    StRemRd, StRemWr, StInsRd, StInsWr, StOut
  } state_e;

  state_e state_q;
  region_t mem_q [TableEntries];
  region_t rd_q;
  logic [IdxW-1:0] rd_addr;
  logic rd_en, wr_en;
  logic [IdxW-1:0] wr_addr;
  region_t wr_data;

  logic func_q;
  logic [DataW-1:0] addr_q, size_q;
  logic [CntW-1:0] idx_q, pos_q, cnt_q, peak_q;
  logic [DataW-1:0] total_q, lost_cnt_q, lost_bytes_q, got_q;
  logic status_q;
  region_t cur_q, prev_q, shift_q;
  logic have_cur_q, have_prev_q;

  // memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = idx_q[IdxW-1:0];
    wr_en = 1'b0;
    wr_addr = idx_q[IdxW-1:0];
    wr_data = shift_q;
    case (state_q)
      StScanRd: rd_en = 1'b1;
      StPrevRd: begin
        rd_en = 1'b1;
        rd_addr = IdxW'(pos_q - 1'b1);
      end
      StRemRd: rd_en = 1'b1;
      StRemWr: begin
        wr_en = 1'b1;
        wr_addr = IdxW'(idx_q - 1'b1);
        wr_data = rd_q;
      end
      StInsRd: begin
        rd_en = 1'b1;
        rd_addr = IdxW'(idx_q - 1'b1);
      end
      StInsWr: begin
        wr_en = 1'b1;
        // shift source for insert
        if (have_cur_q) wr_data = rd_q;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      peak_q <= '0;
      total_q <= '0;
      lost_cnt_q <= '0;
      lost_bytes_q <= '0;
      idx_q <= '0;
      pos_q <= '0;
      func_q <= 1'b0;
      addr_q <= '0;
      size_q <= '0;
      status_q <= 1'b0;
      got_q <= '0;
      cur_q <= '0;
      prev_q <= '0;
      shift_q <= '0;
      have_cur_q <= 1'b0;
      have_prev_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            func_q <= s_axis_tuser;
            addr_q <= s_axis_tdata[31:0];
            size_q <= s_axis_tdata[63:32];
            idx_q <= '0;
            got_q <= '0;
            status_q <= 1'b0;
            have_cur_q <= 1'b0;
            state_q <= StScanRd;
          end
        end
        StScanRd: begin
          if (idx_q >= cnt_q) begin
            // end of table
            pos_q <= idx_q;
            have_cur_q <= 1'b0;
            state_q <= (func_q == FuncAlloc) ? StOut : StPrevRd;
          end else begin
            state_q <= StScanChk;
          end
        end
        StScanChk: begin
          if (func_q == FuncAlloc) begin
            if (rd_q.length >= size_q) begin
              got_q <= rd_q.start;
              total_q <= total_q - size_q;
              pos_q <= idx_q;
              if (rd_q.length == size_q) begin
                // entry empties: close the gap
                cnt_q <= cnt_q - 1'b1;
                idx_q <= idx_q + 1'b1;
                state_q <= StRemRd;
              end else begin
                // write back the shrunk entry, nothing to remove afterwards
                shift_q <= '{start: rd_q.start + size_q, length: rd_q.length - size_q};
                func_q <= FuncFree;
                state_q <= StInsWr;
                cnt_q <= cnt_q;
              end
            end else begin
              idx_q <= idx_q + 1'b1;
              state_q <= StScanRd;
            end
          end else if (rd_q.start > addr_q) begin
            pos_q <= idx_q;
            cur_q <= rd_q;
            have_cur_q <= 1'b1;
            state_q <= StPrevRd;
          end else begin
            idx_q <= idx_q + 1'b1;
            state_q <= StScanRd;
          end
        end
        StPrevRd: begin
          have_prev_q <= (pos_q != '0);
          state_q <= StPrevChk;
        end
        StPrevChk: begin
          prev_q <= rd_q;
          state_q <= StDecide;
        end
        StDecide: begin
          if (have_prev_q && (prev_q.start + prev_q.length == addr_q)) begin
            total_q <= total_q + size_q;
            idx_q <= pos_q - 1'b1;
            if (have_cur_q && (addr_q + size_q == cur_q.start)) begin
              // merge both sides, then remove the following entry
              shift_q <= '{start: prev_q.start,
                           length: prev_q.length + size_q + cur_q.length};
              cnt_q <= cnt_q - 1'b1;
              func_q <= FuncAlloc;
            end else begin
              shift_q <= '{start: prev_q.start, length: prev_q.length + size_q};
              func_q <= FuncFree;
            end
            state_q <= StInsWr;
            have_cur_q <= 1'b0;
          end else if (have_cur_q && (addr_q + size_q == cur_q.start)) begin
            total_q <= total_q + size_q;
            idx_q <= pos_q;
            shift_q <= '{start: addr_q, length: cur_q.length + size_q};
            func_q <= FuncFree;
            have_cur_q <= 1'b0;
            state_q <= StInsWr;
          end else if (cnt_q < CntW'(TableEntries)) begin
            total_q <= total_q + size_q;
            cnt_q <= cnt_q + 1'b1;
            if (peak_q < cnt_q + 1'b1) peak_q <= cnt_q + 1'b1;
            idx_q <= cnt_q;
            have_cur_q <= 1'b1;
            state_q <= StInsRd;
          end else begin
            status_q <= 1'b1;
            lost_cnt_q <= lost_cnt_q + 1'b1;
            lost_bytes_q <= lost_bytes_q + size_q;
            state_q <= StOut;
          end
        end
        StInsRd: begin
          // shift up from the top down to the insert point
          if (idx_q == pos_q) begin
            shift_q <= '{start: addr_q, length: size_q};
            have_cur_q <= 1'b0;
            func_q <= FuncFree;
            state_q <= StInsWr;
          end else begin
            state_q <= StInsWr;
          end
        end
        StInsWr: begin
          if (have_cur_q) begin
            idx_q <= idx_q - 1'b1;
            state_q <= StInsRd;
          end else if (func_q == FuncAlloc) begin
            // merged into previous; remove entry at pos
            func_q <= FuncFree;
            idx_q <= pos_q + 1'b1;
            state_q <= StRemRd;
          end else begin
            state_q <= StOut;
          end
        end
        StRemRd: begin
          if (idx_q > cnt_q) state_q <= StOut;
          else state_q <= StRemWr;
        end
        StRemWr: begin
          idx_q <= idx_q + 1'b1;
          state_q <= StRemRd;
        end
        StOut: if (m_axis_tready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tuser = status_q;
  assign m_axis_tdata = {6'b0, lost_bytes_q, lost_cnt_q, peak_q, cnt_q, total_q, got_q};

  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= cnt_q || state_q != StIdle)
    else $error("peak below count");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(TableEntries))
    else $error("count overflow");
  a_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> func_q == FuncFree)
    else $error("drop on allocate");

endmodule
